// File: rtl/ohr_pkg.sv
// ----------------------------------------------------------------------------
// ohr_pkg
// Types and constants shared by the overwriting history ring modules.
// ----------------------------------------------------------------------------
package ohr_pkg;

  localparam int CAP_W  = 7;
  localparam int KIND_W = 2;
  localparam int SEEN_W = 32;

  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FLUSH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_FLUSH,
    OP_CLEAR
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } back_state_t;

  // Head of the request queue as seen by the back part.
  typedef struct packed {
    logic valid;
    op_t  op;
  } req_head_t;

  // Output buffer status used by the back part for read credit.
  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } oq_stat_t;

endpackage

// File: rtl/ohr_front.sv
// ----------------------------------------------------------------------------
// ohr_front
// Accepts and classifies requests; holds known kinds in a two-entry queue.
// ----------------------------------------------------------------------------
module ohr_front #(
  parameter int RECORD_BITS = 64,
  parameter int IN_W        = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [IN_W-1:0]             in_tdata,
  input  logic [ohr_pkg::KIND_W-1:0]  in_tuser,
  output ohr_pkg::req_head_t          head,
  output logic [RECORD_BITS-1:0]      head_rec,
  input  logic                        head_pop
);

  ohr_pkg::op_t           op_r [2];
  logic [RECORD_BITS-1:0] rec_r [2];
  logic                   wr_ptr_r, wr_ptr_nxt;
  logic                   rd_ptr_r, rd_ptr_nxt;
  logic [1:0]             count_r, count_nxt;
  logic                   accept;
  logic                   enq;
  ohr_pkg::op_t           cls_op;

  assign in_tready = (count_r != 2'd2);
  assign accept    = in_tvalid & in_tready;

  always_comb begin
    enq    = 1'b0;
    cls_op = ohr_pkg::OP_PUSH;
    case (in_tuser)
      ohr_pkg::KIND_PUSH: begin
        enq    = accept;
        cls_op = ohr_pkg::OP_PUSH;
      end
      ohr_pkg::KIND_FLUSH: begin
        enq    = accept;
        cls_op = ohr_pkg::OP_FLUSH;
      end
      ohr_pkg::KIND_CLEAR: begin
        enq    = accept;
        cls_op = ohr_pkg::OP_CLEAR;
      end
      default: begin
        enq = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ enq;
    rd_ptr_nxt = rd_ptr_r ^ head_pop;
    count_nxt  = count_r + {1'b0, enq} - {1'b0, head_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      op_r[wr_ptr_r]  <= cls_op;
      rec_r[wr_ptr_r] <= in_tdata[RECORD_BITS-1:0];
    end
  end

  assign head.valid = (count_r != 2'd0);
  assign head.op    = op_r[rd_ptr_r];
  assign head_rec   = rec_r[rd_ptr_r];

endmodule

// File: rtl/ohr_back.sv
// ----------------------------------------------------------------------------
// ohr_back
// Holds the ring state and record memory, executes pushes, clears and flushes.
// ----------------------------------------------------------------------------
module ohr_back #(
  parameter int DEPTH       = 64,
  parameter int RECORD_BITS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ohr_pkg::CAP_W-1:0]   cfg_wr_data,
  input  ohr_pkg::req_head_t          head,
  input  logic [RECORD_BITS-1:0]      head_rec,
  output logic                        head_pop,
  input  ohr_pkg::oq_stat_t           oq_stat,
  output logic                        rd_valid,
  output logic [RECORD_BITS-1:0]      rd_rec,
  output logic                        rd_last,
  output logic [ohr_pkg::SEEN_W-1:0]  rd_seen
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = ohr_pkg::CAP_W + 1;

  ohr_pkg::back_state_t       state_r, state_nxt;
  logic [ohr_pkg::CAP_W-1:0]  cap_r, cap_nxt;
  logic [PTR_W-1:0]           wp_r, wp_nxt;
  logic [CNT_W-1:0]           fill_r, fill_nxt;
  logic [ohr_pkg::SEEN_W-1:0] pcount_r, pcount_nxt;
  logic [PTR_W-1:0]           idx_r, idx_nxt;
  logic [CNT_W-1:0]           remain_r, remain_nxt;
  logic                       inflight_r;
  logic [RECORD_BITS-1:0]     rd_data_r;
  logic                       rd_last_r;
  logic [ohr_pkg::SEEN_W-1:0] rd_seen_r;
  logic [RECORD_BITS-1:0]     mem [DEPTH];

  logic [SUM_W-1:0] cap8, wp8, fill8, idx8, wp_inc8, idx_inc8, first8;
  logic             mem_we;
  logic             issue;
  logic             credit_ok;

  assign cap8 = (cap_r > ohr_pkg::CAP_W'(DEPTH)) ? SUM_W'(DEPTH) : SUM_W'(cap_r);
  assign wp8      = SUM_W'(wp_r);
  assign fill8    = SUM_W'(fill_r);
  assign idx8     = SUM_W'(idx_r);
  assign wp_inc8  = wp8 + SUM_W'(1);
  assign idx_inc8 = idx8 + SUM_W'(1);

  always_comb begin
    first8 = wp8 + cap8 - fill8;
    if (first8 >= cap8) begin
      first8 = first8 - cap8;
    end
  end

  assign credit_ok = (3'(oq_stat.count) + 3'(inflight_r)) <= (3'd1 + 3'(oq_stat.pop));

  always_comb begin
    state_nxt  = state_r;
    cap_nxt    = cap_r;
    wp_nxt     = wp_r;
    fill_nxt   = fill_r;
    pcount_nxt = pcount_r;
    idx_nxt    = idx_r;
    remain_nxt = remain_r;
    head_pop   = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    case (state_r)
      ohr_pkg::ST_IDLE: begin
        if (head.valid) begin
          head_pop = 1'b1;
          case (head.op)
            ohr_pkg::OP_PUSH: begin
              pcount_nxt = pcount_r + ohr_pkg::SEEN_W'(1);
              if (cap8 != '0) begin
                mem_we = 1'b1;
                wp_nxt = (wp_inc8 == cap8) ? '0 : PTR_W'(wp_inc8);
                if (fill8 < cap8) begin
                  fill_nxt = fill_r + CNT_W'(1);
                end
              end
            end
            ohr_pkg::OP_FLUSH: begin
              if (cap8 != '0 && fill_r != '0) begin
                state_nxt  = ohr_pkg::ST_FLUSH;
                idx_nxt    = PTR_W'(first8);
                remain_nxt = fill_r;
              end
            end
            ohr_pkg::OP_CLEAR: begin
              wp_nxt     = '0;
              fill_nxt   = '0;
              pcount_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ohr_pkg::ST_FLUSH: begin
        if (credit_ok) begin
          issue      = 1'b1;
          remain_nxt = remain_r - CNT_W'(1);
          idx_nxt    = (idx_inc8 == cap8) ? '0 : PTR_W'(idx_inc8);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = ohr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ohr_pkg::ST_IDLE;
      end
    endcase
    if (cfg_wr_en) begin
      cap_nxt    = cfg_wr_data;
      wp_nxt     = '0;
      fill_nxt   = '0;
      pcount_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ohr_pkg::ST_IDLE;
      cap_r      <= '0;
      wp_r       <= '0;
      fill_r     <= '0;
      pcount_r   <= '0;
      idx_r      <= '0;
      remain_r   <= '0;
      inflight_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cap_r      <= cap_nxt;
      wp_r       <= wp_nxt;
      fill_r     <= fill_nxt;
      pcount_r   <= pcount_nxt;
      idx_r      <= idx_nxt;
      remain_r   <= remain_nxt;
      inflight_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wp_r] <= head_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data_r <= mem[idx_r];
      rd_last_r <= (remain_r == CNT_W'(1));
      rd_seen_r <= pcount_r;
    end
  end

  assign rd_valid = inflight_r;
  assign rd_rec   = rd_data_r;
  assign rd_last  = rd_last_r;
  assign rd_seen  = rd_seen_r;

endmodule

// File: rtl/ohr_out_q.sv
// ----------------------------------------------------------------------------
// ohr_out_q
// Two-entry output buffer that decouples memory reads from the result stream.
// ----------------------------------------------------------------------------
module ohr_out_q #(
  parameter int RECORD_BITS = 64,
  parameter int OUT_W       = 96
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_valid,
  input  logic [RECORD_BITS-1:0]      rd_rec,
  input  logic                        rd_last,
  input  logic [ohr_pkg::SEEN_W-1:0]  rd_seen,
  output ohr_pkg::oq_stat_t           oq_stat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [OUT_W-1:0]            out_tdata,
  output logic                        out_tlast
);

  logic [RECORD_BITS-1:0]     rec_r  [2];
  logic                       last_r [2];
  logic [ohr_pkg::SEEN_W-1:0] seen_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 count_r, count_nxt;
  logic                       pop;

  assign out_tvalid = (count_r != 2'd0);
  assign pop        = out_tvalid & out_tready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ rd_valid;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, rd_valid} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid) begin
      rec_r[wr_ptr_r]  <= rd_rec;
      last_r[wr_ptr_r] <= rd_last;
      seen_r[wr_ptr_r] <= rd_seen;
    end
  end

  assign oq_stat.count = count_r;
  assign oq_stat.pop   = pop;
  assign out_tdata     = OUT_W'({seen_r[rd_ptr_r], rec_r[rd_ptr_r]});
  assign out_tlast     = last_r[rd_ptr_r];

endmodule

// File: rtl/overwriting_history_ring.sv
// A push or clear request takes effect on the ring when the idle back part pops it.
// Pushes are accepted one per cycle while the queue has room; the ring updates once
// per cycle from the queue unless flushing. A flush emits its n held records one per
// cycle while the output is not stalled, set by the single record memory read port.
// Reset is synchronous and active low; it clears control state and the capacity
// register, while the record memory is not cleared.
// ----------------------------------------------------------------------------
// overwriting_history_ring
// Keeps the most recent records in a ring of configurable capacity and emits
// them oldest first on a flush request.
// ----------------------------------------------------------------------------
module overwriting_history_ring #(
  parameter int DEPTH       = 64,
  parameter int RECORD_BITS = 64
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_wr_en,
  input  logic [ohr_pkg::CAP_W-1:0]                     cfg_wr_data,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // record_in
  input  logic [((RECORD_BITS+7)/8)*8-1:0]              in_tdata,
  // kind
  input  logic [ohr_pkg::KIND_W-1:0]                    in_tuser,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // record_out, seen_total
  output logic [((RECORD_BITS+ohr_pkg::SEEN_W+7)/8)*8-1:0] out_tdata,
  output logic                                          out_tlast
);

  localparam int IN_W  = ((RECORD_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((RECORD_BITS + ohr_pkg::SEEN_W + 7) / 8) * 8;

  ohr_pkg::req_head_t         head;
  logic [RECORD_BITS-1:0]     head_rec;
  logic                       head_pop;
  ohr_pkg::oq_stat_t          oq_stat;
  logic                       rd_valid;
  logic [RECORD_BITS-1:0]     rd_rec;
  logic                       rd_last;
  logic [ohr_pkg::SEEN_W-1:0] rd_seen;

  ohr_front #(
    .RECORD_BITS (RECORD_BITS),
    .IN_W        (IN_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .head_rec  (head_rec),
    .head_pop  (head_pop)
  );

  ohr_back #(
    .DEPTH       (DEPTH),
    .RECORD_BITS (RECORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .head        (head),
    .head_rec    (head_rec),
    .head_pop    (head_pop),
    .oq_stat     (oq_stat),
    .rd_valid    (rd_valid),
    .rd_rec      (rd_rec),
    .rd_last     (rd_last),
    .rd_seen     (rd_seen)
  );

  ohr_out_q #(
    .RECORD_BITS (RECORD_BITS),
    .OUT_W       (OUT_W)
  ) u_out_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_valid   (rd_valid),
    .rd_rec     (rd_rec),
    .rd_last    (rd_last),
    .rd_seen    (rd_seen),
    .oq_stat    (oq_stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// File: dv/overwriting_history_ring_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_history_ring_tb
// Drives push, flush, clear and unused requests into the history ring under
// several capacity settings, with random gaps on the request side and random
// stalls on the result side. A scoreboard keeps its own copy of the ring,
// predicts every flushed record and checks each result field by field.
// ----------------------------------------------------------------------------

typedef struct {
  logic [63:0] record;
  logic        last;
  logic [31:0] seen;
} flushed_record_t;

class ring_scoreboard;

  logic [63:0]     slots [64];
  int unsigned     write_pos;
  int unsigned     fill_count;
  logic [31:0]     push_count;
  int unsigned     capacity;
  flushed_record_t flushed_q[$];
  int unsigned     errors;

  function new();
    capacity = 0;
    errors   = 0;
    restart();
  endfunction

  function void restart();
    write_pos  = 0;
    fill_count = 0;
    push_count = '0;
  endfunction

  function void write_capacity(input logic [6:0] value);
    capacity = {25'd0, value};
    restart();
  endfunction

  function int unsigned pending();
    return flushed_q.size();
  endfunction

  function void note_request(input logic [1:0] kind, input logic [63:0] rec);
    int unsigned     cap;
    int unsigned     pos;
    int unsigned     n;
    int unsigned     first;
    flushed_record_t item;
    cap = (capacity > 64) ? 64 : capacity;
    case (kind)
      ohr_pkg::KIND_PUSH: begin
        if (cap != 0) begin
          pos        = write_pos % cap;
          slots[pos] = rec;
          write_pos  = (pos + 1) % cap;
          if (fill_count < cap) fill_count++;
        end
        push_count = push_count + 32'd1;
      end
      ohr_pkg::KIND_FLUSH: begin
        if (cap != 0 && fill_count != 0) begin
          n     = (fill_count > cap) ? cap : fill_count;
          first = ((write_pos % cap) + cap - n) % cap;
          for (int unsigned k = 0; k < n; k++) begin
            item.record = slots[(first + k) % cap];
            item.last   = (k + 1 == n);
            item.seen   = push_count;
            flushed_q.insert(flushed_q.size(), item);
          end
        end
      end
      ohr_pkg::KIND_CLEAR: begin
        restart();
      end
      default: begin
      end
    endcase
  endfunction

  task report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  task check_result(input logic [63:0] rec, input logic last, input logic [31:0] seen);
    flushed_record_t exp;
    if (flushed_q.size() == 0) begin
      report($sformatf("unexpected result record=%h last=%b seen=%0d", rec, last, seen));
    end else begin
      exp = flushed_q.pop_front();
      if (rec !== exp.record)
        report($sformatf("record_out %h, expected %h", rec, exp.record));
      if (last !== exp.last)
        report($sformatf("is_last %b, expected %b", last, exp.last));
      if (seen !== exp.seen)
        report($sformatf("seen_total %0d, expected %0d", seen, exp.seen));
    end
  endtask

endclass

module overwriting_history_ring_tb;

  localparam logic [1:0] KIND_UNUSED  = 2'd3;
  localparam int         SETTLE_TICKS = 12;
  localparam int         STALL_LIMIT  = 1500;
  localparam int         NUM_PHASES   = 8;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic        out_tlast;

  ring_scoreboard sb;
  bit             steady_in;
  int unsigned    quiet_cycles;

  overwriting_history_ring #(
    .DEPTH       (64),
    .RECORD_BITS (64)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [63:0] pick_record();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_request(input logic [1:0] kind, input logic [63:0] rec);
    int unsigned gap;
    gap = steady_in ? 0 : pick_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= rec;
    do @(posedge clk); while (!in_tready);
    sb.note_request(kind, rec);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    sb.write_capacity(value);
  endtask

  task automatic run_phase(input logic [6:0] cap, input int unsigned count);
    int unsigned sent;
    int unsigned r;
    int unsigned flush_pct;
    logic [1:0]  kind;
    write_capacity(cap);
    steady_in = ($urandom_range(0, 3) == 0);
    flush_pct = (cap >= 64) ? 2 : 15;
    sent      = 0;
    while (sent < count) begin
      r = $urandom_range(0, 99);
      if (r < 4) kind = KIND_UNUSED;
      else if (r < 4 + flush_pct) kind = ohr_pkg::KIND_FLUSH;
      else if (r < 8 + flush_pct) kind = ohr_pkg::KIND_CLEAR;
      else kind = ohr_pkg::KIND_PUSH;
      send_request(kind, pick_record());
      if (kind != KIND_UNUSED) sent++;
    end
    send_request(ohr_pkg::KIND_FLUSH, pick_record());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[63:0], out_tlast, out_tdata[95:64]);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned gap;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      gap = pick_gap();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  initial begin
    logic [6:0] cap;
    sb           = new();
    quiet_cycles = 0;
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = ohr_pkg::KIND_PUSH;
    steady_in    = 1'b1;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With the reset capacity of zero, pushes are only counted.
    send_request(ohr_pkg::KIND_PUSH, '1);
    send_request(ohr_pkg::KIND_FLUSH, '0);
    send_request(KIND_UNUSED, '1);
    send_request(ohr_pkg::KIND_CLEAR, '0);
    wait_drained();

    write_capacity(7'd3);
    send_request(ohr_pkg::KIND_FLUSH, '0);
    send_request(ohr_pkg::KIND_PUSH, 64'h0000_0000_0000_0000);
    send_request(ohr_pkg::KIND_PUSH, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(ohr_pkg::KIND_PUSH, 64'h5555_5555_5555_5555);
    send_request(ohr_pkg::KIND_PUSH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(ohr_pkg::KIND_FLUSH, '1);
    send_request(ohr_pkg::KIND_FLUSH, '0);
    send_request(ohr_pkg::KIND_CLEAR, '1);
    send_request(ohr_pkg::KIND_FLUSH, '0);
    send_request(ohr_pkg::KIND_PUSH, 64'h8000_0000_0000_0001);
    send_request(KIND_UNUSED, 64'h1234_5678_9ABC_DEF0);
    send_request(ohr_pkg::KIND_FLUSH, '0);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0:       cap = 7'd1;
        1:       cap = 7'd64;
        2:       cap = 7'd127;
        3:       cap = 7'd0;
        4:       cap = 7'($urandom_range(65, 126));
        default: cap = 7'($urandom_range(1, 63));
      endcase
      run_phase(cap, (cap >= 64) ? 65 : 35);
    end

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/ohr_pkg.sv
rtl/ohr_front.sv
rtl/ohr_back.sv
rtl/ohr_out_q.sv
rtl/overwriting_history_ring.sv
dv/overwriting_history_ring_tb.sv
